// ===== design/cbp_pkg.sv =====
// shared types and constants for the column cloud band percentage block
package cbp_pkg;

    localparam int unsigned CNT_W      = 7;
    localparam int unsigned PCT_W      = 15;
    localparam int unsigned NUM_W      = 22;
    localparam int unsigned NUM_BANDS  = 3;
    localparam int unsigned THR_W      = 16;
    localparam int unsigned STEP_W     = 4;
    localparam int unsigned PCT_FULL   = 25600;
    localparam int unsigned DIV_STEPS  = PCT_W;
    localparam int unsigned Q_DEPTH    = 4;
    localparam int unsigned Q_AW       = 2;
    localparam int unsigned Q_CW       = 3;
    localparam int unsigned OUT_W      = 48;

    // register indexes on the apb port
    localparam logic REG_LOW_THR  = 1'b0;
    localparam logic REG_HIGH_THR = 1'b1;

    typedef enum logic [1:0] {
        BAND_LOW  = 2'd0,
        BAND_MID  = 2'd1,
        BAND_HIGH = 2'd2
    } band_t;

    typedef struct packed {
        logic [CNT_W-1:0] level;
        logic [CNT_W-1:0] cloudy;
    } band_cnt_t;

    typedef band_cnt_t [NUM_BANDS-1:0] col_cnt_t;

    typedef struct packed {
        logic            full;
        logic            empty;
        logic [Q_CW-1:0] count;
    } q_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_OUT
    } back_state_t;

endpackage

// ===== design/cbp_front.sv =====
// front part: band classification and per-band level and cloudy counters
module cbp_front #(
    parameter int unsigned CNT_CAP = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_fire,
    input  logic [cbp_pkg::THR_W-1:0]   pressure,
    input  logic [cbp_pkg::THR_W-1:0]   cloud_fraction,
    input  logic                        last_level,
    input  logic [cbp_pkg::THR_W-1:0]   low_thr,
    input  logic [cbp_pkg::THR_W-1:0]   high_thr,
    output logic                        push,
    output cbp_pkg::col_cnt_t           push_data
);

    localparam logic [cbp_pkg::CNT_W-1:0] CAP = cbp_pkg::CNT_W'(CNT_CAP);

    cbp_pkg::col_cnt_t cnt_reg;
    cbp_pkg::col_cnt_t cnt_next;
    cbp_pkg::col_cnt_t tallied;
    cbp_pkg::band_t    band_sel;
    logic              is_cloudy;

    always_comb begin
        priority if (pressure > low_thr) begin
            band_sel = cbp_pkg::BAND_LOW;
        end else if (pressure > high_thr) begin
            band_sel = cbp_pkg::BAND_MID;
        end else begin
            band_sel = cbp_pkg::BAND_HIGH;
        end
        is_cloudy = |cloud_fraction;

        tallied = cnt_reg;
        for (int b = 0; b < int'(cbp_pkg::NUM_BANDS); b++) begin
            if (band_sel == cbp_pkg::band_t'(b)) begin
                // saturate level count, cloudy count never passes it
                if (cnt_reg[b].level < CAP) begin
                    tallied[b].level = cnt_reg[b].level + 1'b1;
                end
                if (is_cloudy && (cnt_reg[b].cloudy < tallied[b].level)) begin
                    tallied[b].cloudy = cnt_reg[b].cloudy + 1'b1;
                end
            end
        end

        cnt_next = cnt_reg;
        if (in_fire) begin
            cnt_next = last_level ? '0 : tallied;
        end
        push      = in_fire && last_level;
        push_data = tallied;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== design/cbp_queue.sv =====
// small fifo of finished column counts between front and back
module cbp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  cbp_pkg::col_cnt_t push_data,
    input  logic              pop,
    output cbp_pkg::col_cnt_t pop_data,
    output cbp_pkg::q_stat_t  stat
);

    cbp_pkg::col_cnt_t             q_mem [cbp_pkg::Q_DEPTH];
    cbp_pkg::col_cnt_t             head_reg;
    logic [cbp_pkg::Q_AW-1:0]      wr_ptr_reg;
    logic [cbp_pkg::Q_AW-1:0]      rd_ptr_reg;
    logic [cbp_pkg::Q_CW-1:0]      count_reg;
    logic [cbp_pkg::Q_AW-1:0]      wr_ptr_next;
    logic [cbp_pkg::Q_AW-1:0]      rd_ptr_next;
    logic [cbp_pkg::Q_CW-1:0]      count_next;
    logic                          do_push;
    logic                          do_pop;

    always_comb begin
        stat.count = count_reg;
        stat.full  = (count_reg == cbp_pkg::Q_CW'(cbp_pkg::Q_DEPTH));
        stat.empty = (count_reg == '0);
        do_push    = push && !stat.full;
        do_pop     = pop && !stat.empty;
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
        pop_data = head_reg;
    end

    // head entry is registered; a push into the head slot passes straight through
    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem[wr_ptr_reg] <= push_data;
        end
        if (do_push && (wr_ptr_reg == rd_ptr_next)) begin
            head_reg <= push_data;
        end else begin
            head_reg <= q_mem[rd_ptr_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/cbp_back.sv =====
// back part: shared radix-2 divider for the three band percentages and output register
module cbp_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cbp_pkg::q_stat_t              q_stat,
    input  cbp_pkg::col_cnt_t             q_data,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cbp_pkg::OUT_W-1:0]     m_tdata
);

    localparam logic [cbp_pkg::NUM_W-1:0] FULL_SCALE = cbp_pkg::NUM_W'(cbp_pkg::PCT_FULL);

    cbp_pkg::back_state_t              state_reg, state_next;
    cbp_pkg::band_t                    band_reg, band_next;
    logic [cbp_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [cbp_pkg::CNT_W-1:0]         rem_reg, rem_next;
    logic [cbp_pkg::PCT_W-1:0]         quo_reg, quo_next;
    logic [cbp_pkg::CNT_W-1:0]         div_reg, div_next;
    cbp_pkg::col_cnt_t                 cols_reg, cols_next;
    logic [cbp_pkg::NUM_BANDS-1:0][cbp_pkg::PCT_W-1:0] pct_reg, pct_next;
    logic                              out_valid_reg, out_valid_next;
    logic [cbp_pkg::OUT_W-1:0]         out_data_reg, out_data_next;

    logic [cbp_pkg::CNT_W:0]           trial;
    logic [cbp_pkg::CNT_W:0]           diff;
    logic                              ge;
    logic [cbp_pkg::PCT_W-1:0]         quo_step;
    logic [cbp_pkg::CNT_W-1:0]         rem_step;
    cbp_pkg::band_cnt_t                load_cnt;
    logic [cbp_pkg::NUM_W-1:0]         load_num;
    cbp_pkg::band_t                    load_band;
    logic                              load;

    always_comb begin
        state_next     = state_reg;
        band_next      = band_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_next       = div_reg;
        cols_next      = cols_reg;
        pct_next       = pct_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        load           = 1'b0;
        load_band      = cbp_pkg::BAND_LOW;
        load_cnt       = q_data[cbp_pkg::BAND_LOW];

        // one quotient bit per cycle, remainder stays below the divisor
        trial    = {rem_reg, quo_reg[cbp_pkg::PCT_W-1]};
        diff     = trial - {1'b0, div_reg};
        ge       = (trial >= {1'b0, div_reg});
        rem_step = ge ? diff[cbp_pkg::CNT_W-1:0] : trial[cbp_pkg::CNT_W-1:0];
        quo_step = {quo_reg[cbp_pkg::PCT_W-2:0], ge};

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            cbp_pkg::BK_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop      = 1'b1;
                    cols_next  = q_data;
                    load       = 1'b1;
                    load_band  = cbp_pkg::BAND_LOW;
                    load_cnt   = q_data[cbp_pkg::BAND_LOW];
                    state_next = cbp_pkg::BK_DIV;
                end
            end
            cbp_pkg::BK_DIV: begin
                rem_next = rem_step;
                quo_next = quo_step;
                step_next = step_reg + 1'b1;
                if (step_reg == cbp_pkg::STEP_W'(cbp_pkg::DIV_STEPS - 1)) begin
                    // empty band reports zero
                    pct_next[band_reg] = (cols_reg[band_reg].level == '0) ? '0 : quo_step;
                    if (band_reg == cbp_pkg::BAND_HIGH) begin
                        state_next = cbp_pkg::BK_OUT;
                    end else begin
                        load      = 1'b1;
                        load_band = cbp_pkg::band_t'(band_reg + 2'd1);
                        load_cnt  = cols_reg[load_band];
                    end
                end
            end
            cbp_pkg::BK_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {
                        (cols_reg[cbp_pkg::BAND_HIGH].level != '0),
                        pct_reg[cbp_pkg::BAND_HIGH],
                        (cols_reg[cbp_pkg::BAND_MID].level != '0),
                        pct_reg[cbp_pkg::BAND_MID],
                        (cols_reg[cbp_pkg::BAND_LOW].level != '0),
                        pct_reg[cbp_pkg::BAND_LOW]
                    };
                    state_next = cbp_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = cbp_pkg::BK_IDLE;
            end
        endcase

        // numerator 25600*cloudy; its top bits are below the divisor
        load_num = FULL_SCALE * cbp_pkg::NUM_W'(load_cnt.cloudy);
        if (load) begin
            band_next = load_band;
            step_next = '0;
            div_next  = load_cnt.level;
            rem_next  = load_num[cbp_pkg::NUM_W-1:cbp_pkg::PCT_W];
            quo_next  = load_num[cbp_pkg::PCT_W-1:0];
        end

        m_tvalid = out_valid_reg;
        m_tdata  = out_data_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= cbp_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        band_reg     <= band_next;
        step_reg     <= step_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        div_reg      <= div_next;
        cols_reg     <= cols_next;
        pct_reg      <= pct_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== design/column_cloud_band_percentage.sv =====
// top level of the column cloud band percentage block
//
//  channel   dir   handshake           content
//  s_        in    s_tvalid/s_tready   one level: pressure, cloud fraction, last mark (tlast)
//  m_        out   m_tvalid/m_tready   one column: percent and valid flag for each band
//  apb       in    psel/penable        band thresholds at 0x0 (low) and 0x4 (high)
//
// the front counts one level per cycle; s_tready drops only while the column queue
// (four entries) is full
// each column result goes through the back in order: a pop, 15 divider steps for
// each of the three bands on the shared divider, then a load of the output register
// reset clears counters, queue, back state and output valid; thresholds go to
// 12800 and 7200
// a stalled output holds the result while the back works on the next column
module column_cloud_band_percentage #(
    parameter int unsigned MAX_LEVELS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // level stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pressure [15:0], cloud_fraction [31:16]
    input  logic        s_tlast,   // last_level
    // column results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // low_percent [14:0], low_valid [15],
                                   // mid_percent [30:16], mid_valid [31],
                                   // high_percent [46:32], high_valid [47]
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // counters saturate at the smaller of the level limit and the counter range
    localparam int unsigned CNT_MAX = (1 << cbp_pkg::CNT_W) - 1;
    localparam int unsigned CNT_CAP = (MAX_LEVELS < CNT_MAX) ? MAX_LEVELS : CNT_MAX;

    logic [cbp_pkg::THR_W-1:0] low_thr_reg, low_thr_next;
    logic [cbp_pkg::THR_W-1:0] high_thr_reg, high_thr_next;
    logic                      cfg_wr;
    logic                      in_fire;
    logic                      q_push;
    logic                      q_pop;
    cbp_pkg::col_cnt_t         q_push_data;
    cbp_pkg::col_cnt_t         q_pop_data;
    cbp_pkg::q_stat_t          q_stat;

    // apb: write on the access beat, zero wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        low_thr_next  = low_thr_reg;
        high_thr_next = high_thr_reg;
        if (cfg_wr) begin
            unique case (paddr[2])
                cbp_pkg::REG_LOW_THR:  low_thr_next  = pwdata[cbp_pkg::THR_W-1:0];
                cbp_pkg::REG_HIGH_THR: high_thr_next = pwdata[cbp_pkg::THR_W-1:0];
                default: ;
            endcase
        end
        unique case (paddr[2])
            cbp_pkg::REG_LOW_THR:  prdata = {16'd0, low_thr_reg};
            cbp_pkg::REG_HIGH_THR: prdata = {16'd0, high_thr_reg};
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_thr_reg  <= 16'd12800;
            high_thr_reg <= 16'd7200;
        end else begin
            low_thr_reg  <= low_thr_next;
            high_thr_reg <= high_thr_next;
        end
    end

    // a level is taken whenever the queue can still hold a finished column
    assign s_tready = !q_stat.full;
    assign in_fire  = s_tvalid && s_tready;

    cbp_front #(
        .CNT_CAP (CNT_CAP)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_fire        (in_fire),
        .pressure       (s_tdata[15:0]),
        .cloud_fraction (s_tdata[31:16]),
        .last_level     (s_tlast),
        .low_thr        (low_thr_reg),
        .high_thr       (high_thr_reg),
        .push           (q_push),
        .push_data      (q_push_data)
    );

    cbp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .stat      (q_stat)
    );

    cbp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_stat   (q_stat),
        .q_data   (q_pop_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef ASSERT_OFF
    // queue occupancy never passes its depth
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= cbp_pkg::Q_CW'(cbp_pkg::Q_DEPTH))
        else $error("column queue overflow");

    // a finished column is never dropped: ready is low only with a full queue
    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_stat.full)
        else $error("input stalled with room in the queue");

    // an empty low band reports zero percent
    a_empty_band: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[15]) |-> (m_tdata[14:0] == '0))
        else $error("empty low band with nonzero percent");

    // percentages never exceed full scale
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[14:0] <= 15'd25600) && (m_tdata[30:16] <= 15'd25600)
                      && (m_tdata[46:32] <= 15'd25600)))
        else $error("band percent above full scale");
`endif

endmodule
